### sv/dss_pkg.sv
// Package for the damped spring stepper: payload structs, micro-op codes,
// the step micro-program and fixed-point constants. No dependencies.
`timescale 1ns / 1ps
package dss_pkg;

  localparam int FRAC_BITS = 16;

  localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
  localparam logic [15:0] DT_MAX     = 16'd6554;
  localparam logic [23:0] RESP_MIN   = 24'd7;
  localparam logic [32:0] SETTLE_POS = 33'(((64'd1 << FRAC_BITS) * 2 + 500) / 1000);
  localparam logic [32:0] SETTLE_VEL = 33'(((64'd1 << FRAC_BITS) * 2 + 50) / 100);

  localparam logic [1:0] FUNC_STEP     = 2'd0;
  localparam logic [1:0] FUNC_RETARGET = 2'd1;
  localparam logic [1:0] FUNC_SET      = 2'd2;
  localparam logic [1:0] FUNC_KICK     = 2'd3;

  localparam logic [1:0] REG_DAMPING  = 2'd0;
  localparam logic [1:0] REG_RESPONSE = 2'd1;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [15:0] dt;
    logic signed [31:0] operand;
  } dss_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic               settled;
  } dss_out_t;

  typedef logic [4:0] dss_op_t;

  localparam dss_op_t OP_NONE      = 5'd0;
  localparam dss_op_t OP_APPLY     = 5'd1;
  localparam dss_op_t OP_RESULT    = 5'd2;
  localparam dss_op_t OP_ZERO      = 5'd3;
  localparam dss_op_t OP_ACC       = 5'd4;
  localparam dss_op_t OP_MUL_TP    = 5'd5;
  localparam dss_op_t OP_DIVA_INIT = 5'd6;
  localparam dss_op_t OP_DIVA_STEP = 5'd7;
  localparam dss_op_t OP_MUL_AA0   = 5'd8;
  localparam dss_op_t OP_MUL_AA1   = 5'd9;
  localparam dss_op_t OP_MUL_AA2   = 5'd10;
  localparam dss_op_t OP_ST_A2     = 5'd11;
  localparam dss_op_t OP_MUL_ZA0   = 5'd12;
  localparam dss_op_t OP_MUL_ZA1   = 5'd13;
  localparam dss_op_t OP_ST_DEN0   = 5'd14;
  localparam dss_op_t OP_MUL_DH0   = 5'd15;
  localparam dss_op_t OP_MUL_DH1   = 5'd16;
  localparam dss_op_t OP_MUL_DH2   = 5'd17;
  localparam dss_op_t OP_ST_DEN    = 5'd18;
  localparam dss_op_t OP_MUL_VH    = 5'd19;
  localparam dss_op_t OP_ST_T1     = 5'd20;
  localparam dss_op_t OP_MUL_T20   = 5'd21;
  localparam dss_op_t OP_MUL_T21   = 5'd22;
  localparam dss_op_t OP_MUL_T22   = 5'd23;
  localparam dss_op_t OP_COMBINE   = 5'd24;
  localparam dss_op_t OP_OVF       = 5'd25;
  localparam dss_op_t OP_DIVQ_STEP = 5'd26;
  localparam dss_op_t OP_VEL       = 5'd27;
  localparam dss_op_t OP_MUL_PH    = 5'd28;
  localparam dss_op_t OP_POS       = 5'd29;

  localparam int DIVA_STEPS = 48;
  localparam int DIVQ_STEPS = 33;
  localparam logic [5:0] PROG_LAST = 6'd40;

  typedef struct packed {
    dss_op_t op;
  } dss_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dss_status_t;

  // Micro-program of one step command.
  function automatic dss_op_t prog_op(input logic [5:0] pc);
    dss_op_t op;
    unique case (pc)
      6'd0:  op = OP_ZERO;
      6'd1:  op = OP_MUL_TP;
      6'd2:  op = OP_ACC;
      6'd3:  op = OP_DIVA_INIT;
      6'd4:  op = OP_DIVA_STEP;
      6'd5:  op = OP_ZERO;
      6'd6:  op = OP_MUL_AA0;
      6'd7:  op = OP_ACC;
      6'd8:  op = OP_MUL_AA1;
      6'd9:  op = OP_ACC;
      6'd10: op = OP_ACC;
      6'd11: op = OP_MUL_AA2;
      6'd12: op = OP_ACC;
      6'd13: op = OP_ST_A2;
      6'd14: op = OP_MUL_ZA0;
      6'd15: op = OP_ACC;
      6'd16: op = OP_MUL_ZA1;
      6'd17: op = OP_ACC;
      6'd18: op = OP_ST_DEN0;
      6'd19: op = OP_MUL_DH0;
      6'd20: op = OP_ACC;
      6'd21: op = OP_MUL_DH1;
      6'd22: op = OP_ACC;
      6'd23: op = OP_MUL_DH2;
      6'd24: op = OP_ACC;
      6'd25: op = OP_ST_DEN;
      6'd26: op = OP_MUL_VH;
      6'd27: op = OP_ACC;
      6'd28: op = OP_ST_T1;
      6'd29: op = OP_MUL_T20;
      6'd30: op = OP_ACC;
      6'd31: op = OP_MUL_T21;
      6'd32: op = OP_ACC;
      6'd33: op = OP_MUL_T22;
      6'd34: op = OP_ACC;
      6'd35: op = OP_COMBINE;
      6'd36: op = OP_OVF;
      6'd37: op = OP_DIVQ_STEP;
      6'd38: op = OP_VEL;
      6'd39: op = OP_MUL_PH;
      6'd40: op = OP_POS;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

### sv/dss_ctrl.sv
// Controller of the damped spring stepper: sequences the micro-program.
// Depends on dss_pkg.
`timescale 1ns / 1ps
module dss_ctrl import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [1:0]  func,
  input  logic        dt_zero,
  input  dss_status_t status,
  output logic        busy,
  output dss_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  dss_op_t    op;

  assign busy = (state_r != S_IDLE);
  assign op   = prog_op(pc_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pc_nxt  = '0;
          cnt_nxt = '0;
          if (func != FUNC_STEP) begin
            state_nxt = S_APPLY;
          end else if (dt_zero) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_APPLY: begin
        cmd.op    = OP_APPLY;
        state_nxt = S_OUT;
      end
      S_RUN: begin
        cmd.op = op;
        if (op == OP_DIVA_STEP && cnt_r != 6'(DIVA_STEPS - 1)) begin
          cnt_nxt = cnt_r + 6'd1;
        end else if (op == OP_DIVQ_STEP && cnt_r != 6'(DIVQ_STEPS - 1)) begin
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          cnt_nxt = '0;
          if (pc_r == PROG_LAST) begin
            state_nxt = S_OUT;
          end else begin
            pc_nxt = pc_r + 6'd1;
          end
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### sv/dss_datapath.sv
// Datapath of the damped spring stepper: state, configuration, shared
// multiplier with accumulator, two shift-subtract dividers, output register.
// Depends on dss_pkg.
`timescale 1ns / 1ps
module dss_datapath import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        accept,
  input  dss_in_t     in_data,
  input  dss_cmd_t    cmd,
  input  logic        out_stall,
  output dss_status_t status,
  output logic        out_valid,
  output dss_out_t    out_data
);

  logic [23:0]  damp_r, resp_r;
  dss_in_t      item_r;
  logic [31:0]  pos_r, goal_r, vel_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [6:0]   sh_r;
  logic [47:0]  diva_r;
  logic [23:0]  rema_r;
  logic [75:0]  a2_r;
  logic [89:0]  den_r;
  logic [91:0]  t1_r;
  logic [122:0] rem_r, dsh_r;
  logic [32:0]  quo_r;
  logic         neg_r, ovf_r;
  dss_out_t     out_r;
  logic         out_valid_r;

  logic [12:0]  h;
  logic [23:0]  r;
  logic [31:0]  d2;
  logic [32:0]  err, em33, diff_mag;
  logic [31:0]  em, vm;
  logic         neg2;
  logic [31:0]  mx, my;
  logic [6:0]   msh;
  logic         is_mul;
  logic [24:0]  rema2;
  logic [122:0] t1w, t2w, dsh0, den33;
  logic [33:0]  stepv, psum;
  logic         settled;

  assign h  = (item_r.dt > DT_MAX) ? DT_MAX[12:0] : item_r.dt[12:0];
  assign r  = (resp_r < RESP_MIN) ? RESP_MIN : resp_r;
  assign d2 = {7'd0, damp_r, 1'b0};

  assign err  = {pos_r[31], pos_r} - {goal_r[31], goal_r};
  assign em33 = err[32] ? (33'd0 - err) : err;
  assign em   = em33[31:0];
  assign neg2 = !err[32] && (err != 33'd0);
  assign vm   = vel_r[31] ? (32'd0 - vel_r) : vel_r;
  assign diff_mag = em33;
  assign settled  = (diff_mag < SETTLE_POS) && ({1'b0, vm} < SETTLE_VEL);

  assign rema2 = {rema_r, diva_r[47]};
  assign t1w   = {31'd0, t1_r};
  assign t2w   = {15'd0, acc_r[107:0]};
  assign dsh0  = {1'b0, den_r, 32'd0};
  assign den33 = {den_r, 33'd0};

  always_comb begin
    is_mul = 1'b1;
    mx     = '0;
    my     = '0;
    msh    = '0;
    unique case (cmd.op)
      OP_MUL_TP:  begin mx = TWO_PI_Q28;           my = {19'd0, h}; msh = 7'd4;  end
      OP_MUL_AA0: begin mx = diva_r[31:0];         my = diva_r[31:0]; end
      OP_MUL_AA1: begin
        mx = diva_r[31:0]; my = {16'd0, diva_r[47:32]}; msh = 7'd32;
      end
      OP_MUL_AA2: begin
        mx = {16'd0, diva_r[47:32]}; my = {16'd0, diva_r[47:32]}; msh = 7'd64;
      end
      OP_MUL_ZA0: begin mx = d2; my = diva_r[31:0]; end
      OP_MUL_ZA1: begin mx = d2; my = {16'd0, diva_r[47:32]}; msh = 7'd32; end
      OP_MUL_DH0: begin mx = den_r[31:0];  my = {19'd0, h}; end
      OP_MUL_DH1: begin mx = den_r[63:32]; my = {19'd0, h}; msh = 7'd32; end
      OP_MUL_DH2: begin mx = {6'd0, den_r[89:64]}; my = {19'd0, h}; msh = 7'd64; end
      OP_MUL_VH:  begin mx = vm; my = {19'd0, h}; msh = 7'd48; end
      OP_MUL_T20: begin mx = a2_r[31:0];  my = em; end
      OP_MUL_T21: begin mx = a2_r[63:32]; my = em; msh = 7'd32; end
      OP_MUL_T22: begin mx = {20'd0, a2_r[75:64]}; my = em; msh = 7'd64; end
      OP_MUL_PH:  begin mx = vm; my = {19'd0, h}; end
      default:    is_mul = 1'b0;
    endcase
  end

  assign stepv = vel_r[31] ? (34'd0 - {6'd0, prod_r[43:16]}) : {6'd0, prod_r[43:16]};
  assign psum  = {{2{pos_r[31]}}, pos_r} + stepv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r      <= 24'd65536;
      resp_r      <= 24'd32768;
      pos_r       <= '0;
      goal_r      <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_DAMPING)  damp_r <= cfg_data;
      if (cfg_we && cfg_index == REG_RESPONSE) resp_r <= cfg_data;
      if (out_valid_r && !out_stall && cmd.op != OP_RESULT) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_APPLY: begin
          unique case (item_r.func)
            FUNC_RETARGET: goal_r <= item_r.operand;
            FUNC_SET: begin
              pos_r  <= item_r.operand;
              goal_r <= item_r.operand;
              vel_r  <= '0;
            end
            FUNC_KICK: vel_r <= item_r.operand;
            default: ;
          endcase
        end
        OP_VEL: begin
          if (neg_r) begin
            vel_r <= (ovf_r || quo_r > 33'h080000000) ? 32'h80000000
                                                       : (32'd0 - quo_r[31:0]);
          end else begin
            vel_r <= (ovf_r || quo_r > 33'h07FFFFFFF) ? 32'h7FFFFFFF : quo_r[31:0];
          end
        end
        OP_POS: begin
          if (!psum[33] && psum[32:31] != 2'b00) begin
            pos_r <= 32'h7FFFFFFF;
          end else if (psum[33] && psum[32:31] != 2'b11) begin
            pos_r <= 32'h80000000;
          end else begin
            pos_r <= psum[31:0];
          end
        end
        OP_RESULT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (is_mul) begin
      prod_r <= mx * my;
      sh_r   <= msh;
    end
    unique case (cmd.op)
      OP_ZERO: acc_r <= '0;
      OP_ACC:  acc_r <= acc_r + ({64'd0, prod_r} << sh_r);
      OP_DIVA_INIT: begin
        diva_r <= acc_r[47:0];
        rema_r <= '0;
      end
      OP_DIVA_STEP: begin
        if (rema2 >= {1'b0, r}) begin
          rema_r <= 24'(rema2 - {1'b0, r});
          diva_r <= {diva_r[46:0], 1'b1};
        end else begin
          rema_r <= rema2[23:0];
          diva_r <= {diva_r[46:0], 1'b0};
        end
      end
      OP_ST_A2: begin
        a2_r  <= acc_r[91:16];
        acc_r <= {52'd0, acc_r[91:16]} + (128'd1 << 48);
      end
      OP_ST_DEN0, OP_ST_DEN: begin
        den_r <= acc_r[89:0];
        acc_r <= '0;
      end
      OP_ST_T1: begin
        t1_r  <= acc_r[91:0];
        acc_r <= '0;
      end
      OP_COMBINE: begin
        if (vel_r[31] == neg2) begin
          rem_r <= t1w + t2w;
          neg_r <= vel_r[31];
        end else if (t1w < t2w) begin
          rem_r <= t2w - t1w;
          neg_r <= neg2;
        end else begin
          rem_r <= t1w - t2w;
          neg_r <= vel_r[31];
        end
      end
      OP_OVF: begin
        ovf_r <= (rem_r >= den33);
        dsh_r <= dsh0;
        quo_r <= '0;
      end
      OP_DIVQ_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[31:0], 1'b1};
        end else begin
          quo_r <= {quo_r[31:0], 1'b0};
        end
        dsh_r <= {1'b0, dsh_r[122:1]};
      end
      OP_RESULT: begin
        out_r.position <= pos_r;
        out_r.speed    <= vel_r;
        out_r.settled  <= settled;
      end
      default: ;
    endcase
  end

  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

### sv/damped_spring_stepper_core.sv
// Top level of the damped spring stepper: controller plus datapath.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
`timescale 1ns / 1ps
// The block holds a spring's position, target and velocity in signed Q16.16
// and takes one command per transaction: step (implicit Euler over dt, with
// dt clamped to 0.1 s), retarget, set position, or kick velocity. Every
// transaction returns one result with position, velocity and a settled flag.
// Items are handled one at a time. A step with dt of zero goes from acceptance
// straight to the output state, and retarget, set and kick pass through the
// apply state first. A full step runs the micro-program before its result: the
// shift-subtract division that forms omega*dt, fourteen passes through the
// shared 32x32 multiplier, all but the last followed by accumulation, and
// the division that forms the new velocity. The result waits in an
// output register, so the next transaction is taken while it is held.
// Configuration writes are taken at any time but belong to idle periods.
module damped_spring_stepper_core import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  dss_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dss_out_t    out_data
);

  logic        accept;
  logic        busy;
  dss_cmd_t    cmd;
  dss_status_t status;

  // Input is stalled while an item is in flight.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  dss_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (in_data.func),
    .dt_zero (in_data.dt == 16'd0),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  dss_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### tb/tb_damped_spring_stepper_core.sv
// Self-checking testbench for damped_spring_stepper_core: random commands and
// register settings, an in-bench spring predictor, randomized valid and stall.
// Depends on dss_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_damped_spring_stepper_core;
  import dss_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DAMPING;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  dss_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dss_out_t    out_data;

  always #5 clk = ~clk;

  damped_spring_stepper_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // Spring state and settings as the predictor tracks them.
  logic [23:0]        damping_q;
  logic [23:0]        period_q;
  logic signed [31:0] spring_pos;
  logic signed [31:0] spring_goal;
  logic signed [31:0] spring_vel;

  dss_in_t  pending_cmds[$];
  dss_out_t expected_states[$];
  int       mismatches = 0;
  longint   cycles = 0;
  localparam longint CYCLE_LIMIT = 2000000;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Implicit Euler update of velocity then position, at the block's widths.
  function automatic void advance_spring(input logic [15:0] dt_in);
    logic [23:0]  r;
    logic [31:0]  h;
    logic [127:0] a, a2, za, den, t1, t2, mag, q;
    logic signed [63:0] err, stp;
    logic [63:0]  em, vm;
    logic         neg1, neg2, neg;
    logic signed [65:0] vnew;
    r = (period_q < RESP_MIN) ? RESP_MIN : period_q;
    if (dt_in == 0) return;
    h = 32'((dt_in > DT_MAX) ? DT_MAX : dt_in);
    a = ((128'(TWO_PI_Q28) * h) << 4) / r;
    a = a[63:0];
    a2 = (a * a) >> 16;
    za = (128'(damping_q) * 2) * a;
    den = ((128'd1 << 48) + za + a2) * h;
    err = 64'(spring_pos) - 64'(spring_goal);
    em = err[63] ? -err : err;
    vm = spring_vel[31] ? -64'(spring_vel) : 64'(spring_vel);
    t1 = (128'(vm) * h) << 48;
    t2 = a2 * em;
    neg1 = spring_vel < 0;
    neg2 = err > 0;
    if (neg1 == neg2) begin
      mag = t1 + t2;
      neg = neg1;
    end else if (t1 < t2) begin
      mag = t2 - t1;
      neg = neg2;
    end else begin
      mag = t1 - t2;
      neg = neg1;
    end
    q = (den == 0) ? 128'd0 : mag / den;
    if (neg) vnew = (q > 128'h80000000) ? -66'sd2147483648 : -$signed({2'b0, q[63:0]});
    else vnew = (q > 128'h7fffffff) ? 66'sd2147483647 : $signed({2'b0, q[63:0]});
    spring_vel = clamp32(vnew);
    stp = (64'(spring_vel) * $signed({32'd0, h})) / 64'sd65536;
    spring_pos = clamp32(66'(spring_pos) + 66'(stp));
  endfunction

  function automatic dss_out_t spring_response(input dss_in_t cmd);
    dss_out_t res;
    logic signed [33:0] d, dm, vm;
    case (cmd.func)
      FUNC_STEP: advance_spring(cmd.dt);
      FUNC_RETARGET: spring_goal = cmd.operand;
      FUNC_SET: begin
        spring_pos = cmd.operand;
        spring_goal = cmd.operand;
        spring_vel = 0;
      end
      default: spring_vel = cmd.operand;
    endcase
    d = 34'(spring_pos) - 34'(spring_goal);
    dm = d < 0 ? -d : d;
    vm = spring_vel < 0 ? -34'(spring_vel) : 34'(spring_vel);
    res.position = spring_pos;
    res.speed = spring_vel;
    res.settled = (dm < 34'(SETTLE_POS)) && (vm < 34'(SETTLE_VEL));
    return res;
  endfunction

  // Driver: gap drawn per transaction, payload held until accepted.
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && !in_stall) begin
      expected_states.push_back(spring_response(in_data));
      in_gap <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
      if (pending_cmds.size() > 0 && in_gap == 0 && $urandom_range(0, 3) == 0) begin
        in_data <= pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && rst_n) begin
      if (in_gap > 0) in_gap <= in_gap - 1;
      else if (pending_cmds.size() > 0) begin
        in_data <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: compare each transaction with the oldest prediction.
  int out_wait = 0;
  always @(posedge clk) begin
    dss_out_t want;
    if (out_valid && !out_stall) begin
      if (expected_states.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result %h", out_data);
      end else begin
        want = expected_states.pop_front();
        if (want.position !== out_data.position || want.speed !== out_data.speed ||
            want.settled !== out_data.settled) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected pos %0d vel %0d settled %0d, got %0d %0d %0d",
                     want.position, want.speed, want.settled,
                     out_data.position, out_data.speed, out_data.settled);
        end
      end
      out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else if (rst_n) begin
      if (out_wait > 0) out_wait <= out_wait - 1;
      else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic dss_in_t make_cmd(input logic [1:0] f, input logic [15:0] t,
                                       input logic [31:0] v);
    dss_in_t c;
    c.func = f;
    c.dt = t;
    c.operand = v;
    return c;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DAMPING) damping_q = val;
    else period_q = val;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // A random mix of commands: mostly steps, with some retargets, sets and kicks.
  task automatic queue_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6)
        pending_cmds.push_back(make_cmd(FUNC_STEP,
          ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7000)),
          $urandom));
      else if (sel < 7)
        pending_cmds.push_back(make_cmd(FUNC_RETARGET, 16'd0,
          ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000)));
      else if (sel < 8)
        pending_cmds.push_back(make_cmd(FUNC_SET, 16'($urandom),
          ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000)));
      else
        pending_cmds.push_back(make_cmd(FUNC_KICK, 16'($urandom),
          ($urandom_range(0, 2) == 0) ? $urandom : 32'($signed($urandom_range(0, 200000)) - 100000)));
    end
  endtask

  initial begin
    int ph;
    logic [23:0] damp_set[5];
    logic [23:0] resp_set[5];
    damp_set = '{24'd65536, 24'd0, 24'hffffff, 24'd13107, 24'($urandom)};
    resp_set = '{24'd32768, 24'd0, 24'hffffff, 24'd6, 24'd3000};
    damping_q = 24'd65536;
    period_q = 24'd32768;
    spring_pos = 0;
    spring_goal = 0;
    spring_vel = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: settle at rest, extremes of operand and dt, clamps, saturation.
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd0, 32'hffffffff));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd1000, 0));
    pending_cmds.push_back(make_cmd(FUNC_RETARGET, 16'd0, 32'sh00010000));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd0, 0));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd1092, 0));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'hffff, 32'h7fffffff));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd6555, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 16'hffff, 32'h7fffffff));
    pending_cmds.push_back(make_cmd(FUNC_KICK, 16'd0, 32'h7fffffff));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd6554, 0));
    pending_cmds.push_back(make_cmd(FUNC_RETARGET, 16'd0, 32'h80000000));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd6554, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 16'd0, 32'h80000000));
    pending_cmds.push_back(make_cmd(FUNC_KICK, 16'd0, 32'h80000000));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd6554, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 16'd0, 32'd130));
    pending_cmds.push_back(make_cmd(FUNC_RETARGET, 16'd0, 0));
    pending_cmds.push_back(make_cmd(FUNC_KICK, 16'd0, -32'sd1310));
    pending_cmds.push_back(make_cmd(FUNC_KICK, 16'd0, 32'd1311));
    pending_cmds.push_back(make_cmd(FUNC_SET, 16'd0, 32'd131));
    pending_cmds.push_back(make_cmd(FUNC_STEP, 16'd1, 0));
    drain();

    // Random phases across register settings, extremes included.
    for (ph = 0; ph < 5; ph++) begin
      write_reg(REG_DAMPING, damp_set[ph]);
      write_reg(REG_RESPONSE, resp_set[(ph * 3) % 5]);
      queue_random(180);
      drain();
    end

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
